/* hdl/sorted_unique_key_list_defines.svh */
// Assertion macros shared by the sorted key list RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SORTED_UNIQUE_KEY_LIST_DEFINES_SVH
`define SORTED_UNIQUE_KEY_LIST_DEFINES_SVH

// same-cycle implication
`define SUKL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SUKL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sukl_pkg.sv */
// Package for the sorted key list: request/result structs, codes, and the
// controller/datapath interface structs. No dependencies.
package sukl_pkg;

    localparam int C_CAPACITY = 32;

    localparam logic [2:0] CMD_INSERT    = 3'd0;
    localparam logic [2:0] CMD_DELETE    = 3'd1;
    localparam logic [2:0] CMD_SEARCH    = 3'd2;
    localparam logic [2:0] CMD_LIST_ASC  = 3'd3;
    localparam logic [2:0] CMD_LIST_DESC = 3'd4;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_FOUND     = 3'd6;
    localparam logic [2:0] ST_LISTED    = 3'd7;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] key_out;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic       accept;
        logic       scan_run;
        logic       mv_init;
        logic       mv_up;
        logic       mv_run;
        logic       put;
        logic       cnt_dec;
        logic       list_run;
        logic       resp_load;
        logic [2:0] resp_status;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic scan_hit;
        logic move_done;
        logic list_done;
        logic can_load;
        logic empty;
        logic full;
    } t_dp_status;

endpackage

/* hdl/sukl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sukl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sukl_ctrl.sv */
// Sequencing FSM for the sorted key list: decodes a request and steps the
// datapath through scan, shift, list and response. Uses sukl_pkg.
`include "sorted_unique_key_list_defines.svh"

module sukl_ctrl import sukl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_command,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_PUT,
        S_LIST,
        S_RESP
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [2:0] r_resp, n_resp;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_resp  = r_resp;
        o_cmd   = '0;
        o_cmd.resp_status = r_resp;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_op = i_command;
                    unique case (i_command) inside
                        CMD_INSERT: begin
                            n_state = S_SCAN;
                        end
                        CMD_DELETE, CMD_SEARCH: begin
                            if (i_status.empty) begin
                                n_resp  = ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_LIST_ASC, CMD_LIST_DESC: begin
                            if (i_status.empty) begin
                                n_resp  = ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    unique case (r_op) inside
                        CMD_INSERT: begin
                            if (i_status.scan_hit) begin
                                n_resp  = ST_DUPLICATE;
                                n_state = S_RESP;
                            end else if (i_status.full) begin
                                n_resp  = ST_FULL;
                                n_state = S_RESP;
                            end else begin
                                o_cmd.mv_init = 1'b1;
                                o_cmd.mv_up   = 1'b0;
                                n_state = S_MOVE;
                            end
                        end
                        CMD_DELETE: begin
                            if (i_status.scan_hit) begin
                                o_cmd.mv_init = 1'b1;
                                o_cmd.mv_up   = 1'b1;
                                n_state = S_MOVE;
                            end else begin
                                n_resp  = ST_NOTFOUND;
                                n_state = S_RESP;
                            end
                        end
                        default: begin
                            n_resp  = i_status.scan_hit ? ST_FOUND : ST_NOTFOUND;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                o_cmd.mv_run = 1'b1;
                if (i_status.move_done) begin
                    if (r_op == CMD_INSERT) begin
                        n_state = S_PUT;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                        n_resp  = ST_DELETED;
                        n_state = S_RESP;
                    end
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_resp  = ST_INSERTED;
                n_state = S_RESP;
            end
            S_LIST: begin
                o_cmd.list_run = 1'b1;
                if (i_status.list_done) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_status.can_load) begin
                    o_cmd.resp_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= CMD_INSERT;
            r_resp  <= ST_INSERTED;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_resp  <= n_resp;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `SUKL_ASSERT_NEXT(a_scan_exits, r_state == S_SCAN && i_status.scan_done, r_state != S_SCAN, "scan did not finish")
    `SUKL_ASSERT_IMPL(a_list_nonempty, r_state == S_LIST, !i_status.empty, "list walk on empty set")

endmodule

/* hdl/sukl_datapath.sv */
// Datapath for the sorted key list: key RAM, walk counters for scan/shift/list,
// entry count and output register. Uses sukl_pkg and sukl_ram.
`include "sorted_unique_key_list_defines.svh"

module sukl_datapath import sukl_pkg::*; #(
    parameter int CAPACITY = C_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic signed [31:0] r_key;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_rem, n_rem;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic               r_up, n_up;
    logic [CW-1:0]      r_pos;
    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic               run, can_load, list_load, issue, out_load;
    logic               scan_ge, scan_done, scan_hit;
    logic [CW-1:0]      scan_pos;
    logic [31:0]        w_rdata;
    logic signed [31:0] rd_key;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_wdata;

    sukl_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign rd_key    = $signed(w_rdata);
    assign run       = i_cmd.scan_run | i_cmd.mv_run | i_cmd.list_run;
    assign can_load  = !r_out_valid || i_out_ready;
    assign list_load = i_cmd.list_run && r_pend && can_load;
    assign issue     = run && (r_rem != '0) && (!i_cmd.list_run || !r_pend || list_load);
    assign out_load  = list_load || i_cmd.resp_load;

    // first stored key not below the request key
    assign scan_ge   = r_pend && !(rd_key < r_key);
    assign scan_done = scan_ge || (!r_pend && (r_rem == '0));
    assign scan_hit  = scan_ge && (rd_key == r_key);
    assign scan_pos  = scan_ge ? CW'(r_pidx) : r_count;

    assign w_we    = (i_cmd.mv_run && r_pend) || i_cmd.put;
    assign w_waddr = i_cmd.put ? r_pos[AW-1:0]
                   : (r_up ? r_pidx - AW'(1) : r_pidx + AW'(1));
    assign w_wdata = i_cmd.put ? r_key : w_rdata;

    always_comb begin
        n_idx  = r_idx;
        n_rem  = r_rem;
        n_pend = r_pend;
        n_pidx = r_pidx;
        n_up   = r_up;
        if (i_cmd.accept) begin
            n_rem  = r_count;
            n_pend = 1'b0;
            if (i_in_data.command == CMD_LIST_DESC) begin
                n_idx = r_count - ONE;
                n_up  = 1'b0;
            end else begin
                n_idx = '0;
                n_up  = 1'b1;
            end
        end else if (i_cmd.mv_init) begin
            n_pend = 1'b0;
            n_up   = i_cmd.mv_up;
            if (i_cmd.mv_up) begin
                n_rem = r_count - scan_pos - ONE;
                n_idx = scan_pos + ONE;
            end else begin
                n_rem = r_count - scan_pos;
                n_idx = r_count - ONE;
            end
        end else if (run) begin
            if (issue) begin
                n_idx  = r_up ? r_idx + ONE : r_idx - ONE;
                n_rem  = r_rem - ONE;
                n_pidx = r_idx[AW-1:0];
                n_pend = 1'b1;
            end else if (!i_cmd.list_run || list_load) begin
                n_pend = 1'b0;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.put) begin
            n_count = r_count + ONE;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - ONE;
        end
    end

    always_comb begin
        n_out = r_out;
        if (list_load) begin
            n_out.status  = ST_LISTED;
            n_out.key_out = rd_key;
            n_out.last    = (r_rem == '0);
        end else if (i_cmd.resp_load) begin
            n_out.status  = i_cmd.resp_status;
            n_out.key_out = (i_cmd.resp_status == ST_FOUND) ? r_key : '0;
            n_out.last    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_rem  <= n_rem;
        r_pidx <= n_pidx;
        r_up   <= n_up;
        r_out  <= n_out;
        if (i_cmd.accept) begin
            r_key <= i_in_data.key;
        end
        if (i_cmd.scan_run && scan_done) begin
            r_pos <= scan_pos;
        end
    end

    assign o_status.scan_done = scan_done;
    assign o_status.scan_hit  = scan_hit;
    assign o_status.move_done = (r_rem == '0) && !r_pend;
    assign o_status.list_done = list_load && (r_rem == '0);
    assign o_status.can_load  = can_load;
    assign o_status.empty     = (r_count == '0);
    assign o_status.full      = (r_count == CAP_C);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SUKL_ASSERT_IMPL(a_put_room, i_cmd.put, r_count < CAP_C, "insert into full table")
    `SUKL_ASSERT_IMPL(a_dec_nonempty, i_cmd.cnt_dec, r_count != '0, "delete from empty table")
    `SUKL_ASSERT_IMPL(a_load_free, out_load, can_load, "output register overwritten")

endmodule

/* hdl/sorted_unique_key_list.sv */
// Top level of the sorted key list: controller plus datapath.
// Uses sukl_pkg, sukl_ctrl and sukl_datapath.
//
// Holds up to CAPACITY distinct signed 32-bit keys in ascending order in one
// RAM (one write and one registered read per cycle). One request is worked at
// a time; o_in_ready is high only between requests. A search scans to the
// position of the key. A delete scans to the key and shifts the tail over it.
// An insert scans to its position, shifts the tail one entry per cycle and
// then writes the new key. A list request emits one key per cycle while the
// output is not stalled. A delete, search or list on an empty set goes
// straight to its response. Output stalls hold back responses. Commands 5
// to 7 are taken and dropped.
module sorted_unique_key_list import sukl_pkg::*; #(
    parameter int CAPACITY = C_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sukl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sukl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/sorted_unique_key_list_checker.sv */
`timescale 1ns / 100ps
// Checker for the sorted key list: watches the request and result channels,
// predicts the results of each accepted request and compares them. Uses sukl_pkg.
module sorted_unique_key_list_checker import sukl_pkg::*; #(
    parameter int CAPACITY = C_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_result_count
);

    logic signed [31:0] held_keys [$];
    t_out_item          result_fifo [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
    end

    function automatic int lower_pos(input logic signed [31:0] k);
        int i;
        i = 0;
        while (i < held_keys.size() && held_keys[i] < k) i++;
        return i;
    endfunction

    function automatic void push_result(input logic [2:0] st, input logic signed [31:0] k,
                                        input logic lst);
        t_out_item r;
        r.status  = st;
        r.key_out = k;
        r.last    = lst;
        result_fifo.push_back(r);
    endfunction

    function automatic void predict_request(input t_in_item req);
        int                 pos;
        int                 n;
        logic signed [31:0] k;
        k = req.key;
        n = held_keys.size();
        case (req.command)
            CMD_INSERT: begin
                pos = lower_pos(k);
                if (pos < n && held_keys[pos] == k) begin
                    push_result(ST_DUPLICATE, '0, 1'b1);
                end else if (n >= CAPACITY) begin
                    push_result(ST_FULL, '0, 1'b1);
                end else begin
                    held_keys.insert(pos, k);
                    push_result(ST_INSERTED, '0, 1'b1);
                end
            end
            CMD_DELETE, CMD_SEARCH: begin
                if (n == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    pos = lower_pos(k);
                    if (pos >= n || held_keys[pos] != k) begin
                        push_result(ST_NOTFOUND, '0, 1'b1);
                    end else if (req.command == CMD_SEARCH) begin
                        push_result(ST_FOUND, k, 1'b1);
                    end else begin
                        held_keys.delete(pos);
                        push_result(ST_DELETED, '0, 1'b1);
                    end
                end
            end
            CMD_LIST_ASC, CMD_LIST_DESC: begin
                if (n == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        push_result(ST_LISTED,
                                    (req.command == CMD_LIST_ASC) ? held_keys[i]
                                                                  : held_keys[n - 1 - i],
                                    i == n - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            held_keys.delete();
            result_fifo.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (result_fifo.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: status %0d key %0d last %0d",
                                 i_out_data.status, i_out_data.key_out, i_out_data.last);
                    o_fail_count++;
                end else begin
                    want = result_fifo.pop_front();
                    if (want.status !== i_out_data.status || want.key_out !== i_out_data.key_out
                        || want.last !== i_out_data.last) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch on result %0d: expected status %0d key %0d last %0d",
                                     o_result_count, want.status, want.key_out, want.last);
                            $display("    got status %0d key %0d last %0d",
                                     i_out_data.status, i_out_data.key_out, i_out_data.last);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_request(i_in_data);
        end
        o_pending = result_fifo.size();
    end

endmodule

/* tb/tb_sorted_unique_key_list.sv */
`timescale 1ns / 100ps
// Testbench top for sorted_unique_key_list: clock, reset, request stimulus,
// receiver stalls and verdict. Uses sukl_pkg and sorted_unique_key_list_checker.
module tb_sorted_unique_key_list;
    import sukl_pkg::*;

    localparam logic [2:0] CMD_RSVD_LO   = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI   = 3'd7;
    localparam int         C_POOL        = 40;
    localparam int         C_HOLD_CYCLES = 400;
    localparam int         C_CYCLE_LIMIT = 400000;
    localparam int         C_TAIL_CYCLES = 40;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_data    = '0;
    logic      out_ready  = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    int          fail_count;
    int          pending;
    int          result_count;
    int          snd_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    logic        hold_req      = 1'b0;
    logic        hold_taken    = 1'b0;
    int          hold_left     = 0;
    int          cmd_cnt [8];
    logic [31:0] key_pool [C_POOL];

    sorted_unique_key_list u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sorted_unique_key_list_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= C_HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    initial begin : watchdog
        repeat (C_CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", C_CYCLE_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_req(input logic [2:0] cmd, input logic [31:0] k);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, key: k};
        do @(posedge i_clk); while (!in_ready);
        cmd_cnt[cmd]++;
    endtask

    task automatic send_mixed(input int ins_pct, input int del_pct);
        int          r;
        logic [31:0] k;
        logic [2:0]  cmd;
        r = $urandom_range(0, 99);
        k = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, C_POOL - 1)];
        if (r < ins_pct)                cmd = CMD_INSERT;
        else if (r < ins_pct + del_pct) cmd = CMD_DELETE;
        else if (r < ins_pct + del_pct + 20) cmd = CMD_SEARCH;
        else if (r < ins_pct + del_pct + 28) cmd = CMD_LIST_ASC;
        else if (r < ins_pct + del_pct + 36) cmd = CMD_LIST_DESC;
        else cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        send_req(cmd, k);
    endtask

    // every pool key once, in random order
    task automatic sweep_pool(input logic [2:0] cmd);
        int order [C_POOL];
        int j;
        int t;
        for (int i = 0; i < C_POOL; i++) order[i] = i;
        for (int i = C_POOL - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < C_POOL; i++) send_req(cmd, key_pool[order[i]]);
    endtask

    task automatic drain(input int snd_pct, input int rcv_pct);
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        snd_idle_pct   = snd_pct;
        rcv_stall_pct <= rcv_pct;
    endtask

    initial begin
        foreach (cmd_cnt[i]) cmd_cnt[i] = 0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, key extremes, every command, reserved codes
        send_req(CMD_LIST_ASC,  $urandom);
        send_req(CMD_LIST_DESC, $urandom);
        send_req(CMD_DELETE,    32'd5);
        send_req(CMD_SEARCH,    32'd5);
        send_req(CMD_INSERT,    32'h8000_0000);
        send_req(CMD_INSERT,    32'h7FFF_FFFF);
        send_req(CMD_INSERT,    32'd0);
        send_req(CMD_INSERT,    32'hFFFF_FFFF);
        send_req(CMD_INSERT,    32'd1);
        send_req(CMD_INSERT,    32'h8000_0000);
        send_req(CMD_SEARCH,    32'h7FFF_FFFF);
        send_req(CMD_SEARCH,    32'd2);
        send_req(CMD_DELETE,    32'd12345);
        send_req(CMD_LIST_ASC,  32'hFFFF_FFFF);
        send_req(CMD_LIST_DESC, 32'd0);
        send_req(CMD_RSVD_LO,   32'd1);
        send_req(CMD_RSVD_LO + 3'd1, 32'hAAAA_5555);
        send_req(CMD_RSVD_HI,   32'hFFFF_FFFF);
        send_req(CMD_DELETE,    32'd0);
        send_req(CMD_DELETE,    32'h8000_0000);
        send_req(CMD_DELETE,    32'h7FFF_FFFF);
        send_req(CMD_LIST_ASC,  32'd0);
        send_req(CMD_DELETE,    32'hFFFF_FFFF);
        send_req(CMD_DELETE,    32'd1);
        send_req(CMD_SEARCH,    32'd0);

        // fill past capacity, then duplicate on a full table
        sweep_pool(CMD_INSERT);
        send_req(CMD_INSERT, key_pool[$urandom_range(0, C_POOL - 1)]);
        send_req(CMD_SEARCH, key_pool[$urandom_range(0, C_POOL - 1)]);
        send_req(CMD_LIST_ASC,  $urandom);
        send_req(CMD_LIST_DESC, $urandom);

        drain(62, 0);
        repeat (50) send_mixed(30, 25);

        drain(0, 62);
        hold_req <= 1'b1;
        send_req(CMD_LIST_ASC, $urandom);
        repeat (50) send_mixed(30, 25);

        drain(34, 34);
        repeat (20) send_mixed(15, 40);
        sweep_pool(CMD_DELETE);
        send_req(CMD_LIST_ASC,  $urandom);
        send_req(CMD_INSERT,    $urandom);
        send_req(CMD_LIST_DESC, $urandom);

        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (C_TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Covered %0d inserts, %0d deletes, %0d searches, %0d lists, %0d reserved codes;",
                 cmd_cnt[CMD_INSERT], cmd_cnt[CMD_DELETE], cmd_cnt[CMD_SEARCH],
                 cmd_cnt[CMD_LIST_ASC] + cmd_cnt[CMD_LIST_DESC],
                 cmd_cnt[CMD_RSVD_LO] + cmd_cnt[CMD_RSVD_LO + 3'd1] + cmd_cnt[CMD_RSVD_HI]);
        $display("%0d results checked over four stall mixes with one long output hold-off",
                 result_count);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sorted_unique_key_list.f */
+incdir+hdl
hdl/sukl_pkg.sv
hdl/sukl_ram.sv
hdl/sukl_ctrl.sv
hdl/sukl_datapath.sv
hdl/sorted_unique_key_list.sv
tb/sorted_unique_key_list_checker.sv
tb/tb_sorted_unique_key_list.sv
